/* design/lobm_pkg.sv */
`timescale 1ns / 1ps

package lobm_pkg;

   // Book geometry.
   localparam int ORDER_SLOTS  = 32;
   localparam int SLOT_W       = $clog2(ORDER_SLOTS);
   localparam int PRICE_W      = 10;
   localparam int PRICE_LEVELS = 1 << PRICE_W;
   localparam int LEVEL_W      = PRICE_W + 1;
   localparam int LEVELS       = 1 << LEVEL_W;
   localparam int ROW_BITS     = 32;
   localparam int ROW_SEL_W    = $clog2(ROW_BITS);
   localparam int ROW_W        = LEVEL_W - ROW_SEL_W;
   localparam int ROWS         = 1 << ROW_W;

   // Field widths.
   localparam int ID_W     = 32;
   localparam int QTY_W    = 32;
   localparam int CLIENT_W = 16;

   // Item codes.
   localparam logic OP_PLACE   = 1'b0;
   localparam logic OP_CANCEL  = 1'b1;
   localparam logic SIDE_BUY   = 1'b0;
   localparam logic SIDE_SELL  = 1'b1;
   localparam logic KIND_TRADE = 1'b0;
   localparam logic KIND_FINAL = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_INVALID   = 2'd1,
      STATUS_NOT_FOUND = 2'd2,
      STATUS_FULL      = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_P_ROW,
      ST_P_LOAD,
      ST_P_SRCH,
      ST_P_LVL,
      ST_P_SLOT,
      ST_P_TRADE,
      ST_REST,
      ST_R_WAIT,
      ST_C_RD,
      ST_C_CMP,
      ST_C_OWN,
      ST_C_LVL,
      ST_C_NS,
      ST_C_WALK,
      ST_C_ROW,
      ST_FINAL
   } state_type;

   // One resting order, as held in the slot memory.
   typedef struct packed {
      logic [ID_W-1:0]     order_id;
      logic                side;
      logic [PRICE_W-1:0]  price;
      logic [QTY_W-1:0]    remaining;
      logic [CLIENT_W-1:0] client;
   } slot_rec_type;

   // Head and tail of one price level's queue.
   typedef struct packed {
      logic [SLOT_W-1:0] head;
      logic [SLOT_W-1:0] tail;
   } level_rec_type;

endpackage

/* design/limit_order_book_matcher.sv */
`timescale 1ns / 1ps
// Price-time priority limit order book.
// Input items arrive on req_* (valid/stall): a place (buy or sell with limit
// price, quantity and client) or a cancel (order id and client). Each item
// yields zero or more trade items (kind 0) and then exactly one final item
// (kind 1, last 1) on rsp_*. req_stall is high while an item is in work.
// Steps: an item is first decoded, then the matcher walks the
// opposite side's nonempty bitmap one 32-level row at a time (at most
// 32 rows), reads a level's head and then its order for each fill, and
// rests a remainder by taking a free slot and linking it in. A cancel
// scans the slot memory slot by slot, then walks the level's queue one
// link per cycle. The book walk through these memories sets the rate.
// Results leave through an output register: while it holds an item and
// rsp_stall is high, it keeps that item, and a trade or final step waits.
// Reset is synchronous. After reset the block clears the level bitmap row
// by row, and req_stall stays high during that pass.
module limit_order_book_matcher
   import lobm_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_operation,
   input  logic                req_side,
   input  logic [PRICE_W-1:0]  req_limit_price,
   input  logic [QTY_W-1:0]    req_quantity,
   input  logic [CLIENT_W-1:0] req_client_id,
   input  logic [ID_W-1:0]     req_cancel_id,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_kind,
   output logic [1:0]          rsp_status,
   output logic [ID_W-1:0]     rsp_assigned_id,
   output logic [ID_W-1:0]     rsp_buy_order_id,
   output logic [ID_W-1:0]     rsp_sell_order_id,
   output logic [CLIENT_W-1:0] rsp_buy_client,
   output logic [CLIENT_W-1:0] rsp_sell_client,
   output logic [PRICE_W-1:0]  rsp_trade_price,
   output logic [QTY_W-1:0]    rsp_trade_amount,
   output logic                rsp_last
);

   // Control and item registers.
   state_type             state_ff, state_in;
   logic [ROW_W-1:0]      clr_ff, clr_in;
   logic                  op_ff, op_in;
   logic                  side_ff, side_in;
   logic [PRICE_W-1:0]    price_ff, price_in;
   logic [QTY_W-1:0]      rem_ff, rem_in;
   logic [CLIENT_W-1:0]   client_ff, client_in;
   logic [ID_W-1:0]       cid_ff, cid_in;
   logic [ID_W-1:0]       id_ff, id_in;
   logic [ID_W-1:0]       id_counter_ff, id_counter_in;
   status_type            status_ff, status_in;
   logic [LEVEL_W-1:0]    lvl_ff, lvl_in;
   logic [LEVEL_W-1:0]    lo_ff, lo_in;
   logic [LEVEL_W-1:0]    hi_ff, hi_in;
   logic [ROW_W-1:0]      row_idx_ff, row_idx_in;
   logic [ROW_BITS-1:0]   row_ff, row_in;
   logic [SLOT_W-1:0]     head_ff, head_in;
   logic [SLOT_W-1:0]     tail_ff, tail_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [SLOT_W-1:0]     ns_ff, ns_in;
   logic [SLOT_W-1:0]     walk_ff, walk_in;
   slot_rec_type          rec_ff, rec_in;
   logic [ORDER_SLOTS-1:0] slot_valid_ff, slot_valid_in;

   // Output register.
   logic                  out_valid_ff, out_valid_in;
   logic                  out_kind_ff, out_kind_in;
   logic [1:0]            out_status_ff, out_status_in;
   logic [ID_W-1:0]       out_aid_ff, out_aid_in;
   logic [ID_W-1:0]       out_bid_ff, out_bid_in;
   logic [ID_W-1:0]       out_sid_ff, out_sid_in;
   logic [CLIENT_W-1:0]   out_bc_ff, out_bc_in;
   logic [CLIENT_W-1:0]   out_sc_ff, out_sc_in;
   logic [PRICE_W-1:0]    out_price_ff, out_price_in;
   logic [QTY_W-1:0]      out_amt_ff, out_amt_in;
   logic                  out_last_ff, out_last_in;

   // Memory ports.
   logic                  slot_we;
   logic [SLOT_W-1:0]     slot_wa, slot_ra;
   slot_rec_type          slot_wd, slot_rd;
   logic                  next_we;
   logic [SLOT_W-1:0]     next_wa, next_ra, next_wd, next_rd;
   logic                  lvl_we;
   logic [LEVEL_W-1:0]    lvl_wa, lvl_ra;
   level_rec_type         lvl_wd, lvl_rd;
   logic                  ne_we;
   logic [ROW_W-1:0]      ne_wa, ne_ra;
   logic [ROW_BITS-1:0]   ne_wd, ne_rd;

   // Shared combinational terms.
   logic                  req_accept;
   logic                  out_free;
   logic                  place_bad;
   logic [ROW_BITS-1:0]   masked;
   logic                  found;
   logic [ROW_SEL_W-1:0]  pick;
   logic [QTY_W-1:0]      amt, srem_left, rem_left;
   logic [SLOT_W-1:0]     free_idx;
   logic                  free_any;
   logic                  hit;
   logic [LEVEL_W-1:0]    lvl_own, lo_start, hi_start;
   logic [ROW_BITS-1:0]   lvl_bit;
   logic [ID_W-1:0]       final_aid;

   lobm_ram #(.WIDTH($bits(slot_rec_type)), .DEPTH(ORDER_SLOTS)) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (slot_wa),
      .wr_data (slot_wd),
      .rd_addr (slot_ra),
      .rd_data (slot_rd)
   );

   lobm_ram #(.WIDTH(SLOT_W), .DEPTH(ORDER_SLOTS)) u_next_ram (
      .clock   (clock),
      .wr_en   (next_we),
      .wr_addr (next_wa),
      .wr_data (next_wd),
      .rd_addr (next_ra),
      .rd_data (next_rd)
   );

   lobm_ram #(.WIDTH($bits(level_rec_type)), .DEPTH(LEVELS)) u_level_ram (
      .clock   (clock),
      .wr_en   (lvl_we),
      .wr_addr (lvl_wa),
      .wr_data (lvl_wd),
      .rd_addr (lvl_ra),
      .rd_data (lvl_rd)
   );

   lobm_ram #(.WIDTH(ROW_BITS), .DEPTH(ROWS)) u_nonempty_ram (
      .clock   (clock),
      .wr_en   (ne_we),
      .wr_addr (ne_wa),
      .wr_data (ne_wd),
      .rd_addr (ne_ra),
      .rd_data (ne_rd)
   );

   // Handshake terms.
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !out_valid_ff || !rsp_stall;

   // Item checks and level addresses.
   assign place_bad = (client_ff == '0) || (rem_ff == '0) || (price_ff == '0);
   assign lvl_own   = {side_ff, price_ff};
   assign lo_start  = (side_ff == SIDE_BUY) ? {SIDE_SELL, PRICE_W'(1)} : {SIDE_BUY, price_ff};
   assign hi_start  = (side_ff == SIDE_BUY) ? {SIDE_SELL, price_ff} : {SIDE_BUY, {PRICE_W{1'b1}}};
   assign lvl_bit   = ROW_BITS'(1) << lvl_ff[ROW_SEL_W-1:0];
   assign final_aid = (op_ff == OP_PLACE && status_ff != STATUS_INVALID) ? id_ff : '0;

   // Best nonempty level in the current bitmap row, within the crossing range.
   always_comb begin
      logic [LEVEL_W-1:0] lvl_b;
      masked = '0;
      for (int b = 0; b < ROW_BITS; b++) begin
         lvl_b     = {row_idx_ff, ROW_SEL_W'(b)};
         masked[b] = row_ff[b] && (lvl_b >= lo_ff) && (lvl_b <= hi_ff);
      end
      found = |masked;
      pick  = '0;
      if (side_ff == SIDE_BUY) begin
         for (int b = ROW_BITS - 1; b >= 0; b--) begin
            if (masked[b]) begin
               pick = ROW_SEL_W'(b);
            end
         end
      end else begin
         for (int b = 0; b < ROW_BITS; b++) begin
            if (masked[b]) begin
               pick = ROW_SEL_W'(b);
            end
         end
      end
   end

   // Fill amount against the resting order at the head of the level.
   assign amt       = (rec_ff.remaining < rem_ff) ? rec_ff.remaining : rem_ff;
   assign srem_left = rec_ff.remaining - amt;
   assign rem_left  = rem_ff - amt;

   // Lowest free slot.
   always_comb begin
      free_idx = '0;
      free_any = 1'b0;
      for (int s = ORDER_SLOTS - 1; s >= 0; s--) begin
         if (!slot_valid_ff[s]) begin
            free_idx = SLOT_W'(s);
            free_any = 1'b1;
         end
      end
   end

   // Cancel lookup compare on the slot just read.
   assign hit = slot_valid_ff[slot_ff] && (slot_rd.order_id == cid_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == ROW_W'(ROWS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (op_ff == OP_PLACE) begin
               state_in = place_bad ? ST_FINAL : ST_P_ROW;
            end else begin
               state_in = (client_ff == '0) ? ST_FINAL : ST_C_RD;
            end
         end
         ST_P_ROW:  state_in = ST_P_LOAD;
         ST_P_LOAD: state_in = ST_P_SRCH;
         ST_P_SRCH: begin
            if (found) begin
               state_in = ST_P_LVL;
            end else if (side_ff == SIDE_BUY) begin
               state_in = (row_idx_ff < hi_ff[LEVEL_W-1:ROW_SEL_W]) ? ST_P_ROW : ST_REST;
            end else begin
               state_in = (row_idx_ff > lo_ff[LEVEL_W-1:ROW_SEL_W]) ? ST_P_ROW : ST_REST;
            end
         end
         ST_P_LVL:  state_in = ST_P_SLOT;
         ST_P_SLOT: state_in = ST_P_TRADE;
         ST_P_TRADE: begin
            if (out_free) begin
               if (srem_left != '0 || rem_left == '0) begin
                  state_in = ST_REST;
               end else if (tail_ff == slot_ff) begin
                  state_in = ST_P_SRCH;
               end else begin
                  state_in = ST_P_SLOT;
               end
            end
         end
         ST_REST: begin
            state_in = (rem_ff != '0 && free_any) ? ST_R_WAIT : ST_FINAL;
         end
         ST_R_WAIT: state_in = ST_FINAL;
         ST_C_RD:   state_in = ST_C_CMP;
         ST_C_CMP: begin
            if (hit) begin
               state_in = ST_C_OWN;
            end else if (slot_ff == SLOT_W'(ORDER_SLOTS - 1)) begin
               state_in = ST_FINAL;
            end else begin
               state_in = ST_C_RD;
            end
         end
         ST_C_OWN: begin
            state_in = (rec_ff.client != client_ff) ? ST_FINAL : ST_C_LVL;
         end
         ST_C_LVL: state_in = ST_C_NS;
         ST_C_NS: begin
            if (head_ff == slot_ff) begin
               state_in = (tail_ff == slot_ff) ? ST_C_ROW : ST_FINAL;
            end else begin
               state_in = ST_C_WALK;
            end
         end
         ST_C_WALK: begin
            if (next_rd == slot_ff) begin
               state_in = ST_FINAL;
            end
         end
         ST_C_ROW: state_in = ST_FINAL;
         ST_FINAL: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath, memory controls and result loading.
   always_comb begin
      clr_in        = clr_ff;
      op_in         = op_ff;
      side_in       = side_ff;
      price_in      = price_ff;
      rem_in        = rem_ff;
      client_in     = client_ff;
      cid_in        = cid_ff;
      id_in         = id_ff;
      id_counter_in = id_counter_ff;
      status_in     = status_ff;
      lvl_in        = lvl_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      row_idx_in    = row_idx_ff;
      row_in        = row_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      slot_in       = slot_ff;
      ns_in         = ns_ff;
      walk_in       = walk_ff;
      rec_in        = rec_ff;
      slot_valid_in = slot_valid_ff;

      slot_we = 1'b0;
      slot_wa = slot_ff;
      slot_wd = rec_ff;
      slot_ra = slot_ff;
      next_we = 1'b0;
      next_wa = walk_ff;
      next_wd = ns_ff;
      next_ra = slot_ff;
      lvl_we  = 1'b0;
      lvl_wa  = lvl_ff;
      lvl_wd  = '{head: head_ff, tail: tail_ff};
      lvl_ra  = lvl_ff;
      ne_we   = 1'b0;
      ne_wa   = lvl_ff[LEVEL_W-1:ROW_SEL_W];
      ne_wd   = row_ff;
      ne_ra   = row_idx_ff;

      // The output register empties when its item is taken.
      out_valid_in  = out_valid_ff && rsp_stall;
      out_kind_in   = out_kind_ff;
      out_status_in = out_status_ff;
      out_aid_in    = out_aid_ff;
      out_bid_in    = out_bid_ff;
      out_sid_in    = out_sid_ff;
      out_bc_in     = out_bc_ff;
      out_sc_in     = out_sc_ff;
      out_price_in  = out_price_ff;
      out_amt_in    = out_amt_ff;
      out_last_in   = out_last_ff;

      case (state_ff)
         // Sweep the level bitmap to empty after reset.
         ST_CLEAR: begin
            ne_we  = 1'b1;
            ne_wa  = clr_ff;
            ne_wd  = '0;
            clr_in = clr_ff + ROW_W'(1);
         end
         ST_IDLE: begin
            if (req_accept) begin
               op_in     = req_operation;
               side_in   = req_side;
               price_in  = req_limit_price;
               rem_in    = req_quantity;
               client_in = req_client_id;
               cid_in    = req_cancel_id;
            end
         end
         // Validate, take an order id and set the crossing range.
         ST_DECODE: begin
            status_in = STATUS_OK;
            slot_in   = '0;
            if (op_ff == OP_PLACE) begin
               if (place_bad) begin
                  status_in = STATUS_INVALID;
               end else begin
                  id_in         = id_counter_ff;
                  id_counter_in = id_counter_ff + ID_W'(1);
                  lo_in         = lo_start;
                  hi_in         = hi_start;
                  row_idx_in    = (side_ff == SIDE_BUY) ? lo_start[LEVEL_W-1:ROW_SEL_W]
                                                        : hi_start[LEVEL_W-1:ROW_SEL_W];
               end
            end else if (client_ff == '0) begin
               status_in = STATUS_INVALID;
            end
         end
         ST_P_ROW: begin
            ne_ra = row_idx_ff;
         end
         ST_P_LOAD: begin
            row_in = ne_rd;
         end
         // Enter the best level, or move to the next bitmap row.
         ST_P_SRCH: begin
            if (found) begin
               lvl_in = {row_idx_ff, pick};
               lvl_ra = {row_idx_ff, pick};
            end else if (side_ff == SIDE_BUY) begin
               row_idx_in = row_idx_ff + ROW_W'(1);
            end else begin
               row_idx_in = row_idx_ff - ROW_W'(1);
            end
         end
         ST_P_LVL: begin
            head_in = lvl_rd.head;
            tail_in = lvl_rd.tail;
            slot_in = lvl_rd.head;
            slot_ra = lvl_rd.head;
            next_ra = lvl_rd.head;
         end
         ST_P_SLOT: begin
            rec_in = slot_rd;
            ns_in  = next_rd;
         end
         // Emit one trade and update the resting order and its level.
         ST_P_TRADE: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_kind_in   = KIND_TRADE;
               out_status_in = STATUS_OK;
               out_aid_in    = id_ff;
               out_bid_in    = (side_ff == SIDE_BUY) ? id_ff : rec_ff.order_id;
               out_sid_in    = (side_ff == SIDE_BUY) ? rec_ff.order_id : id_ff;
               out_bc_in     = (side_ff == SIDE_BUY) ? client_ff : rec_ff.client;
               out_sc_in     = (side_ff == SIDE_BUY) ? rec_ff.client : client_ff;
               out_price_in  = rec_ff.price;
               out_amt_in    = amt;
               out_last_in   = 1'b0;
               rem_in        = rem_left;
               if (srem_left == '0) begin
                  slot_valid_in[slot_ff] = 1'b0;
                  if (tail_ff == slot_ff) begin
                     row_in = row_ff & ~lvl_bit;
                     ne_we  = 1'b1;
                     ne_wa  = lvl_ff[LEVEL_W-1:ROW_SEL_W];
                     ne_wd  = row_ff & ~lvl_bit;
                  end else begin
                     lvl_we  = 1'b1;
                     lvl_wd  = '{head: ns_ff, tail: tail_ff};
                     head_in = ns_ff;
                     slot_in = ns_ff;
                     slot_ra = ns_ff;
                     next_ra = ns_ff;
                  end
               end else begin
                  slot_we           = 1'b1;
                  slot_wd           = rec_ff;
                  slot_wd.remaining = srem_left;
               end
            end
         end
         // Look for a free slot and fetch the own level for the remainder.
         ST_REST: begin
            status_in = STATUS_OK;
            if (rem_ff != '0) begin
               if (!free_any) begin
                  status_in = STATUS_FULL;
               end else begin
                  slot_in = free_idx;
                  lvl_in  = lvl_own;
                  lvl_ra  = lvl_own;
                  ne_ra   = lvl_own[LEVEL_W-1:ROW_SEL_W];
               end
            end
         end
         // Write the new order and append it at the tail of its level.
         ST_R_WAIT: begin
            slot_we = 1'b1;
            slot_wd = '{order_id: id_ff, side: side_ff, price: price_ff,
                        remaining: rem_ff, client: client_ff};
            slot_valid_in[slot_ff] = 1'b1;
            lvl_we = 1'b1;
            if ((ne_rd & lvl_bit) != '0) begin
               next_we = 1'b1;
               next_wa = lvl_rd.tail;
               next_wd = slot_ff;
               lvl_wd  = '{head: lvl_rd.head, tail: slot_ff};
            end else begin
               lvl_wd = '{head: slot_ff, tail: slot_ff};
            end
            ne_we = 1'b1;
            ne_wa = lvl_ff[LEVEL_W-1:ROW_SEL_W];
            ne_wd = ne_rd | lvl_bit;
         end
         ST_C_RD: begin
            slot_ra = slot_ff;
         end
         ST_C_CMP: begin
            if (hit) begin
               rec_in = slot_rd;
            end else begin
               slot_in = slot_ff + SLOT_W'(1);
               if (slot_ff == SLOT_W'(ORDER_SLOTS - 1)) begin
                  status_in = STATUS_NOT_FOUND;
               end
            end
         end
         ST_C_OWN: begin
            if (rec_ff.client != client_ff) begin
               status_in = STATUS_INVALID;
            end else begin
               lvl_in  = {rec_ff.side, rec_ff.price};
               lvl_ra  = {rec_ff.side, rec_ff.price};
               next_ra = slot_ff;
            end
         end
         ST_C_LVL: begin
            head_in = lvl_rd.head;
            tail_in = lvl_rd.tail;
            ns_in   = next_rd;
         end
         // Unlink at the head, or start walking the queue.
         ST_C_NS: begin
            if (head_ff == slot_ff) begin
               if (tail_ff == slot_ff) begin
                  ne_ra = lvl_ff[LEVEL_W-1:ROW_SEL_W];
               end else begin
                  lvl_we = 1'b1;
                  lvl_wd = '{head: ns_ff, tail: tail_ff};
                  slot_valid_in[slot_ff] = 1'b0;
               end
            end else begin
               walk_in = head_ff;
               next_ra = head_ff;
            end
         end
         // One link per cycle until the predecessor is found.
         ST_C_WALK: begin
            if (next_rd == slot_ff) begin
               next_we = 1'b1;
               next_wa = walk_ff;
               next_wd = ns_ff;
               if (tail_ff == slot_ff) begin
                  lvl_we = 1'b1;
                  lvl_wd = '{head: head_ff, tail: walk_ff};
               end
               slot_valid_in[slot_ff] = 1'b0;
            end else begin
               walk_in = next_rd;
               next_ra = next_rd;
            end
         end
         ST_C_ROW: begin
            ne_we = 1'b1;
            ne_wa = lvl_ff[LEVEL_W-1:ROW_SEL_W];
            ne_wd = ne_rd & ~lvl_bit;
            slot_valid_in[slot_ff] = 1'b0;
         end
         ST_FINAL: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_kind_in   = KIND_FINAL;
               out_status_in = status_ff;
               out_aid_in    = final_aid;
               out_bid_in    = '0;
               out_sid_in    = '0;
               out_bc_in     = '0;
               out_sc_in     = '0;
               out_price_in  = '0;
               out_amt_in    = '0;
               out_last_in   = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         id_counter_ff <= '0;
         slot_valid_ff <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         id_counter_ff <= id_counter_in;
         slot_valid_ff <= slot_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      side_ff       <= side_in;
      price_ff      <= price_in;
      rem_ff        <= rem_in;
      client_ff     <= client_in;
      cid_ff        <= cid_in;
      id_ff         <= id_in;
      status_ff     <= status_in;
      lvl_ff        <= lvl_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      row_idx_ff    <= row_idx_in;
      row_ff        <= row_in;
      head_ff       <= head_in;
      tail_ff       <= tail_in;
      slot_ff       <= slot_in;
      ns_ff         <= ns_in;
      walk_ff       <= walk_in;
      rec_ff        <= rec_in;
      out_kind_ff   <= out_kind_in;
      out_status_ff <= out_status_in;
      out_aid_ff    <= out_aid_in;
      out_bid_ff    <= out_bid_in;
      out_sid_ff    <= out_sid_in;
      out_bc_ff     <= out_bc_in;
      out_sc_ff     <= out_sc_in;
      out_price_ff  <= out_price_in;
      out_amt_ff    <= out_amt_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_kind          = out_kind_ff;
   assign rsp_status        = out_status_ff;
   assign rsp_assigned_id   = out_aid_ff;
   assign rsp_buy_order_id  = out_bid_ff;
   assign rsp_sell_order_id = out_sid_ff;
   assign rsp_buy_client    = out_bc_ff;
   assign rsp_sell_client   = out_sc_ff;
   assign rsp_trade_price   = out_price_ff;
   assign rsp_trade_amount  = out_amt_ff;
   assign rsp_last          = out_last_ff;

`ifndef ASSERT_OFF
   // A trade is only emitted while the incoming order has quantity left.
   a_trade_has_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_P_TRADE) |-> (rem_ff != '0))
      else $error("trade step with no quantity left");

   // The slot chosen for a remainder must be free when it is written.
   a_rest_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_R_WAIT) |-> !slot_valid_ff[slot_ff])
      else $error("remainder written into an occupied slot");

   // The queue walk never steps onto the order being cancelled.
   a_walk_not_self: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_C_WALK) |-> (walk_ff != slot_ff))
      else $error("cancel walk reached its own slot");

   // Matching never takes a second order id.
   a_id_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_P_TRADE) |=> $stable(id_counter_ff))
      else $error("order id counter moved during matching");
`endif

endmodule

/* design/lobm_ram.sv */
`timescale 1ns / 1ps

module lobm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
